@@ rtl/core/lrupr_pkg.sv @@
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared constants and types for the LRU page replacement block: default
// sizes, fixed port widths, and the control groups carried along the chain.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	localparam int FRAME_COUNT_DEF = 16;
	localparam int PAGE_BITS_DEF   = 16;

	localparam int CFG_W        = 5;
	localparam int PAGE_PORT_W  = 16;
	localparam int FRAME_IDX_W  = 4;
	localparam int CNT_W        = 32;

	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd3;
	localparam logic [CNT_W-1:0] CNT_MAX           = '1;

	// flags of the search word travelling along the row of frames
	typedef struct packed {
		logic valid;
		logic hit_found;
		logic empty_found;
		logic max_found;
	} srch_flags_t;

	// update broadcast to every frame at the end of a search
	typedef struct packed {
		logic en;
		logic was_valid;
		logic write;
	} upd_ctrl_t;

endpackage

@@ rtl/core/lrupr_cell.sv @@
// ----------------------------------------------------------------------------
// lrupr_cell
// One frame: page, valid mark and recency rank. Folds its own frame into the
// search word from its left neighbor and registers the result for the right
// neighbor. Applies the recency/fill update broadcast at the end of a search.
// ----------------------------------------------------------------------------
module lrupr_cell #(
	parameter int IDX = 0,
	parameter int IW  = 4,
	parameter int PB  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 active,
	// search word from the left neighbor
	input  lrupr_pkg::srch_flags_t in_flags,
	input  logic [PB-1:0]        in_page,
	input  logic [IW-1:0]        in_hit_idx,
	input  logic [IW-1:0]        in_hit_rank,
	input  logic [IW-1:0]        in_empty_idx,
	input  logic [IW-1:0]        in_max_idx,
	input  logic [IW-1:0]        in_max_rank,
	input  logic [PB-1:0]        in_max_page,
	// search word to the right neighbor
	output lrupr_pkg::srch_flags_t out_flags,
	output logic [PB-1:0]        out_page,
	output logic [IW-1:0]        out_hit_idx,
	output logic [IW-1:0]        out_hit_rank,
	output logic [IW-1:0]        out_empty_idx,
	output logic [IW-1:0]        out_max_idx,
	output logic [IW-1:0]        out_max_rank,
	output logic [PB-1:0]        out_max_page,
	// update broadcast
	input  lrupr_pkg::upd_ctrl_t upd,
	input  logic [IW-1:0]        upd_idx,
	input  logic [IW-1:0]        upd_old_rank,
	input  logic [PB-1:0]        upd_page
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [PB-1:0] page_q;
	logic          valid_q;
	logic [IW-1:0] rank_q;

	lrupr_pkg::srch_flags_t flags_q;
	logic [PB-1:0] srch_page_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] hit_rank_q;
	logic [IW-1:0] empty_idx_q;
	logic [IW-1:0] max_idx_q;
	logic [IW-1:0] max_rank_q;
	logic [PB-1:0] max_page_q;

	logic take_hit;
	logic take_empty;
	logic take_max;

	assign take_hit   = in_flags.valid && active && valid_q && (page_q == in_page)
		&& !in_flags.hit_found;
	assign take_empty = in_flags.valid && active && !valid_q && !in_flags.empty_found;
	// strict compare keeps the lowest-numbered frame among equal ranks
	assign take_max   = in_flags.valid && active
		&& (!in_flags.max_found || (rank_q > in_max_rank));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q.valid       <= in_flags.valid;
			flags_q.hit_found   <= in_flags.hit_found | take_hit;
			flags_q.empty_found <= in_flags.empty_found | take_empty;
			flags_q.max_found   <= in_flags.max_found | take_max;
		end
	end

	always_ff @(posedge clk) begin
		srch_page_q <= in_page;
		hit_idx_q   <= take_hit ? MY_IDX : in_hit_idx;
		hit_rank_q  <= take_hit ? rank_q : in_hit_rank;
		empty_idx_q <= take_empty ? MY_IDX : in_empty_idx;
		max_idx_q   <= take_max ? MY_IDX : in_max_idx;
		max_rank_q  <= take_max ? rank_q : in_max_rank;
		max_page_q  <= take_max ? page_q : in_max_page;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q  <= '0;
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			if (upd_idx == MY_IDX) begin
				rank_q <= '0;
				if (upd.write) begin
					page_q  <= upd_page;
					valid_q <= 1'b1;
				end
			end else if (valid_q && (!upd.was_valid || (rank_q < upd_old_rank))) begin
				rank_q <= rank_q + IW'(1);
			end
		end
	end

	assign out_flags     = flags_q;
	assign out_page      = srch_page_q;
	assign out_hit_idx   = hit_idx_q;
	assign out_hit_rank  = hit_rank_q;
	assign out_empty_idx = empty_idx_q;
	assign out_max_idx   = max_idx_q;
	assign out_max_rank  = max_rank_q;
	assign out_max_page  = max_page_q;

endmodule

@@ rtl/core/lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page replacement over a row of frame cells.
//
//   channel  signals                                         direction
//   input    in_valid, in_ready, page_number                 in
//   output   out_valid, out_ready, is_hit, frame_index,      out
//            evicted_valid, evicted_page, hit_total, fault_total
//   config   cfg_we, cfg_wdata (frames_in_use)               in
//
// A reference walks the row one frame per cycle; the decision from the last
// frame goes to the held result register and then, once it is free, to the
// output register, and in_ready returns as the result enters it.
// Reset empties all frames, clears ranks and totals, frames_in_use = 3.
// A stalled result waits in the output register; the next reference is taken
// while it waits and its own result holds until the register frees up.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
	parameter int FRAME_COUNT = lrupr_pkg::FRAME_COUNT_DEF,
	parameter int PAGE_BITS   = lrupr_pkg::PAGE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lrupr_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lrupr_pkg::PAGE_PORT_W-1:0] page_number,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              is_hit,
	output logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index,
	output logic                              evicted_valid,
	output logic [lrupr_pkg::PAGE_PORT_W-1:0] evicted_page,
	output logic [lrupr_pkg::CNT_W-1:0]       hit_total,
	output logic [lrupr_pkg::CNT_W-1:0]       fault_total
);

	localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int PB = PAGE_BITS;
	localparam int WW = (PB > lrupr_pkg::PAGE_PORT_W) ? PB : lrupr_pkg::PAGE_PORT_W;
	localparam int FW = (IW > lrupr_pkg::FRAME_IDX_W) ? IW : lrupr_pkg::FRAME_IDX_W;
	localparam int CW = lrupr_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_RESULT = 3'b100
	} state_t;

	state_t state_q;

	logic [lrupr_pkg::CFG_W-1:0] fiu_q;
	logic [31:0] fiu32;
	logic [31:0] act32;

	logic [CW-1:0] hit_cnt_q;
	logic [CW-1:0] fault_cnt_q;

	// chain links, link 0 is the injection point
	lrupr_pkg::srch_flags_t lk_flags [FRAME_COUNT+1];
	logic [PB-1:0] lk_page      [FRAME_COUNT+1];
	logic [IW-1:0] lk_hit_idx   [FRAME_COUNT+1];
	logic [IW-1:0] lk_hit_rank  [FRAME_COUNT+1];
	logic [IW-1:0] lk_empty_idx [FRAME_COUNT+1];
	logic [IW-1:0] lk_max_idx   [FRAME_COUNT+1];
	logic [IW-1:0] lk_max_rank  [FRAME_COUNT+1];
	logic [PB-1:0] lk_max_page  [FRAME_COUNT+1];

	logic [FRAME_COUNT-1:0] cell_active;

	logic          in_fire;
	logic [WW-1:0] page_wide;

	lrupr_pkg::srch_flags_t tail;
	logic          done;
	lrupr_pkg::upd_ctrl_t upd;
	logic [IW-1:0] dec_idx;
	logic [IW-1:0] dec_old_rank;
	logic          dec_evict;
	logic [PB-1:0] dec_ev_page;
	logic [FW-1:0] dec_idx_wide;
	logic [WW-1:0] ev_wide;

	logic [CW-1:0] hit_cnt_nxt;
	logic [CW-1:0] fault_cnt_nxt;

	// held result, waiting for the output register
	logic                              res_hit_q;
	logic [lrupr_pkg::FRAME_IDX_W-1:0] res_idx_q;
	logic                              res_ev_valid_q;
	logic [lrupr_pkg::PAGE_PORT_W-1:0] res_ev_page_q;
	logic [CW-1:0]                     res_hit_tot_q;
	logic [CW-1:0]                     res_fault_tot_q;

	logic                              out_valid_q;
	logic                              out_hit_q;
	logic [lrupr_pkg::FRAME_IDX_W-1:0] out_idx_q;
	logic                              out_ev_valid_q;
	logic [lrupr_pkg::PAGE_PORT_W-1:0] out_ev_page_q;
	logic [CW-1:0]                     out_hit_tot_q;
	logic [CW-1:0]                     out_fault_tot_q;

	logic slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= lrupr_pkg::FRAMES_IN_USE_RST;
		end else if (cfg_we) begin
			fiu_q <= cfg_wdata;
		end
	end

	// clamp frames_in_use to 1..FRAME_COUNT
	assign fiu32 = 32'(fiu_q);
	assign act32 = (fiu32 == 32'd0) ? 32'd1
		: ((fiu32 > 32'(FRAME_COUNT)) ? 32'(FRAME_COUNT) : fiu32);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign page_wide = WW'(page_number);

	always_comb begin
		lk_flags[0]       = '0;
		lk_flags[0].valid = in_fire;
	end
	assign lk_page[0]      = page_wide[PB-1:0];
	assign lk_hit_idx[0]   = '0;
	assign lk_hit_rank[0]  = '0;
	assign lk_empty_idx[0] = '0;
	assign lk_max_idx[0]   = '0;
	assign lk_max_rank[0]  = '0;
	assign lk_max_page[0]  = '0;

	for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
		assign cell_active[i] = (act32 > 32'(i));

		lrupr_cell #(
			.IDX (i),
			.IW  (IW),
			.PB  (PB)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.active        (cell_active[i]),
			.in_flags      (lk_flags[i]),
			.in_page       (lk_page[i]),
			.in_hit_idx    (lk_hit_idx[i]),
			.in_hit_rank   (lk_hit_rank[i]),
			.in_empty_idx  (lk_empty_idx[i]),
			.in_max_idx    (lk_max_idx[i]),
			.in_max_rank   (lk_max_rank[i]),
			.in_max_page   (lk_max_page[i]),
			.out_flags     (lk_flags[i+1]),
			.out_page      (lk_page[i+1]),
			.out_hit_idx   (lk_hit_idx[i+1]),
			.out_hit_rank  (lk_hit_rank[i+1]),
			.out_empty_idx (lk_empty_idx[i+1]),
			.out_max_idx   (lk_max_idx[i+1]),
			.out_max_rank  (lk_max_rank[i+1]),
			.out_max_page  (lk_max_page[i+1]),
			.upd           (upd),
			.upd_idx       (dec_idx),
			.upd_old_rank  (dec_old_rank),
			.upd_page      (lk_page[FRAME_COUNT])
		);
	end

	// decision from the search word leaving the last frame
	assign tail = lk_flags[FRAME_COUNT];
	assign done = tail.valid && (state_q == ST_SCAN);

	always_comb begin
		upd.en        = done;
		upd.was_valid = tail.hit_found || !tail.empty_found;
		upd.write     = !tail.hit_found;
		dec_evict     = !tail.hit_found && !tail.empty_found;
		if (tail.hit_found) begin
			dec_idx      = lk_hit_idx[FRAME_COUNT];
			dec_old_rank = lk_hit_rank[FRAME_COUNT];
		end else if (tail.empty_found) begin
			dec_idx      = lk_empty_idx[FRAME_COUNT];
			dec_old_rank = '0;
		end else begin
			dec_idx      = lk_max_idx[FRAME_COUNT];
			dec_old_rank = lk_max_rank[FRAME_COUNT];
		end
		dec_ev_page = dec_evict ? lk_max_page[FRAME_COUNT] : '0;
	end

	assign dec_idx_wide = FW'(dec_idx);
	assign ev_wide      = WW'(dec_ev_page);

	assign hit_cnt_nxt = (tail.hit_found && (hit_cnt_q != lrupr_pkg::CNT_MAX))
		? hit_cnt_q + CW'(1) : hit_cnt_q;
	assign fault_cnt_nxt = (!tail.hit_found && (fault_cnt_q != lrupr_pkg::CNT_MAX))
		? fault_cnt_q + CW'(1) : fault_cnt_q;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (done) begin
						hit_cnt_q   <= hit_cnt_nxt;
						fault_cnt_q <= fault_cnt_nxt;
						state_q     <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_hit_q       <= tail.hit_found;
			res_idx_q       <= dec_idx_wide[lrupr_pkg::FRAME_IDX_W-1:0];
			res_ev_valid_q  <= dec_evict;
			res_ev_page_q   <= ev_wide[lrupr_pkg::PAGE_PORT_W-1:0];
			res_hit_tot_q   <= hit_cnt_nxt;
			res_fault_tot_q <= fault_cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && slot_free) begin
			out_hit_q       <= res_hit_q;
			out_idx_q       <= res_idx_q;
			out_ev_valid_q  <= res_ev_valid_q;
			out_ev_page_q   <= res_ev_page_q;
			out_hit_tot_q   <= res_hit_tot_q;
			out_fault_tot_q <= res_fault_tot_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_hit        = out_hit_q;
	assign frame_index   = out_idx_q;
	assign evicted_valid = out_ev_valid_q;
	assign evicted_page  = out_ev_page_q;
	assign hit_total     = out_hit_tot_q;
	assign fault_total   = out_fault_tot_q;

endmodule

@@ rtl/core/lrupr_checker.sv @@
// ----------------------------------------------------------------------------
// lrupr_checker
// Port-level checks for lru_page_replacement, bound to the top level.
// ----------------------------------------------------------------------------
module lrupr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_we,
	input logic [lrupr_pkg::CFG_W-1:0]       cfg_wdata,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [lrupr_pkg::PAGE_PORT_W-1:0] page_number,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              is_hit,
	input logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index,
	input logic                              evicted_valid,
	input logic [lrupr_pkg::PAGE_PORT_W-1:0] evicted_page,
	input logic [lrupr_pkg::CNT_W-1:0]       hit_total,
	input logic [lrupr_pkg::CNT_W-1:0]       fault_total
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_hit) && $stable(frame_index)
			&& $stable(evicted_page) && $stable(hit_total) && $stable(fault_total))
		else $error("result changed while stalled");

	// one reference at a time: no back-to-back acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted in consecutive cycles");

	// a hit is counted before it is reported
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_hit |-> hit_total != '0)
		else $error("hit reported with zero hit total");

	// a fault is counted before it is reported
	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_hit |-> fault_total != '0)
		else $error("fault reported with zero fault total");

	// evictions only on faults, and no evicted page without an eviction
	a_evict_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!evicted_valid || !is_hit) && (evicted_valid || evicted_page == '0))
		else $error("eviction report inconsistent with hit");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);

@@ verif/lru_page_replacement_tb.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement_tb
// Drives page references into the LRU replacement block and checks every
// result against an in-bench LRU frame table: fills of empty frames, hits with
// recency update, evictions of the least recent frame, running totals, and
// the frames_in_use setting including out-of-range and shrink/grow cases.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NFRAMES = lrupr_pkg::FRAME_COUNT_DEF;

	typedef struct {
		logic                              hit;
		logic [lrupr_pkg::FRAME_IDX_W-1:0] frame;
		logic                              ev_valid;
		logic [lrupr_pkg::PAGE_PORT_W-1:0] ev_page;
		logic [lrupr_pkg::CNT_W-1:0]       hits;
		logic [lrupr_pkg::CNT_W-1:0]       faults;
	} page_ref_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [lrupr_pkg::CFG_W-1:0]       cfg_wdata = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [lrupr_pkg::PAGE_PORT_W-1:0] page_number = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic                              is_hit;
	logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index;
	logic                              evicted_valid;
	logic [lrupr_pkg::PAGE_PORT_W-1:0] evicted_page;
	logic [lrupr_pkg::CNT_W-1:0]       hit_total;
	logic [lrupr_pkg::CNT_W-1:0]       fault_total;

	// frame table mirror
	logic [lrupr_pkg::PAGE_PORT_W-1:0] resident_page [NFRAMES];
	logic                              resident_valid [NFRAMES];
	int unsigned                       frame_age [NFRAMES];
	logic [lrupr_pkg::CNT_W-1:0]       hit_count;
	logic [lrupr_pkg::CNT_W-1:0]       fault_count;
	logic [lrupr_pkg::CFG_W-1:0]       frames_cfg;

	page_ref_result_t pending_results [$];

	int  errors = 0;
	int  n_refs = 0;
	int  n_hits = 0;
	int  n_evictions = 0;
	int  n_settings = 0;
	bit  throttle_in = 1'b0;
	bit  throttle_out = 1'b0;
	int  burst_left = 0;
	int  ready_run_left = 0;

	lru_page_replacement i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_hit       (is_hit),
		.frame_index  (frame_index),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.hit_total    (hit_total),
		.fault_total  (fault_total)
	);

	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("lru_page_replacement test failed");
		$finish;
	end

	function automatic int unsigned active_frames();
		if (frames_cfg == 0)
			return 1;
		if (frames_cfg > NFRAMES)
			return NFRAMES;
		return 32'(frames_cfg);
	endfunction

	function automatic void make_recent(input int unsigned f, input bit was_valid);
		int unsigned old_age;
		old_age = frame_age[f];
		for (int unsigned j = 0; j < NFRAMES; j++) begin
			if (j != f && resident_valid[j] && (!was_valid || frame_age[j] < old_age))
				frame_age[j]++;
		end
		frame_age[f] = 0;
	endfunction

	function automatic logic [lrupr_pkg::CNT_W-1:0] sat_inc(
		input logic [lrupr_pkg::CNT_W-1:0] c);
		return (c == lrupr_pkg::CNT_MAX) ? c : c + 1'b1;
	endfunction

	// one reference against the frame table, returns what the block must report
	function automatic page_ref_result_t lru_lookup(
		input logic [lrupr_pkg::PAGE_PORT_W-1:0] pg);
		page_ref_result_t r;
		int unsigned act;
		int unsigned f;
		bit found;
		act = active_frames();
		f = 0;
		found = 1'b0;
		r.hit = 1'b0;
		r.ev_valid = 1'b0;
		r.ev_page = '0;
		for (int unsigned j = 0; j < act; j++) begin
			if (!found && resident_valid[j] && resident_page[j] == pg) begin
				f = j;
				found = 1'b1;
			end
		end
		if (found) begin
			r.hit = 1'b1;
			hit_count = sat_inc(hit_count);
			make_recent(f, 1'b1);
		end else begin
			fault_count = sat_inc(fault_count);
			for (int unsigned j = 0; j < act; j++) begin
				if (!found && !resident_valid[j]) begin
					f = j;
					found = 1'b1;
				end
			end
			if (found) begin
				make_recent(f, 1'b0);
				resident_valid[f] = 1'b1;
			end else begin
				// oldest rank wins, lowest frame on a tie
				f = 0;
				for (int unsigned j = 1; j < act; j++) begin
					if (frame_age[j] > frame_age[f])
						f = j;
				end
				r.ev_valid = 1'b1;
				r.ev_page = resident_page[f];
				make_recent(f, 1'b1);
			end
			resident_page[f] = pg;
		end
		r.frame = f[lrupr_pkg::FRAME_IDX_W-1:0];
		r.hits = hit_count;
		r.faults = fault_count;
		n_refs++;
		if (r.hit)
			n_hits++;
		if (r.ev_valid)
			n_evictions++;
		return r;
	endfunction

	task automatic send_page(input logic [lrupr_pkg::PAGE_PORT_W-1:0] pg);
		int gap;
		if (throttle_in && burst_left == 0) begin
			gap = $urandom_range(1, 25);
			burst_left = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		page_number <= pg;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(lru_lookup(pg));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_frames(input logic [lrupr_pkg::CFG_W-1:0] n);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		frames_cfg = n;
		n_settings++;
	endtask

	// receiver stalls in runs of random length
	always @(posedge clk) begin
		if (!throttle_out) begin
			out_ready <= 1'b1;
		end else if (ready_run_left == 0) begin
			if (out_ready) begin
				out_ready <= 1'b0;
				ready_run_left = $urandom_range(1, 30);
			end else begin
				out_ready <= 1'b1;
				ready_run_left = $urandom_range(1, 12);
			end
		end else begin
			ready_run_left--;
		end
	end

	always @(posedge clk) begin : check_results
		page_ref_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no reference pending");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (is_hit !== want.hit) begin
					$error("is_hit: expected %0d, got %0d", want.hit, is_hit);
					errors++;
				end
				if (frame_index !== want.frame) begin
					$error("frame_index: expected %0d, got %0d", want.frame, frame_index);
					errors++;
				end
				if (evicted_valid !== want.ev_valid) begin
					$error("evicted_valid: expected %0d, got %0d", want.ev_valid,
						evicted_valid);
					errors++;
				end
				if (evicted_page !== want.ev_page) begin
					$error("evicted_page: expected %0h, got %0h", want.ev_page, evicted_page);
					errors++;
				end
				if (hit_total !== want.hits) begin
					$error("hit_total: expected %0d, got %0d", want.hits, hit_total);
					errors++;
				end
				if (fault_total !== want.faults) begin
					$error("fault_total: expected %0d, got %0d", want.faults, fault_total);
					errors++;
				end
			end
		end
	end

	// fill, hit, and evictions with the reset setting of three frames
	task automatic test_reset_setting();
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h0000);
		send_page(16'hAAAA);
		send_page(16'h5555);
		send_page(16'hFFFF);
	endtask

	// zero behaves as one frame, values above the frame count clamp
	task automatic test_frame_limits();
		set_frames(5'd0);
		send_page(16'hFFFF);
		send_page(16'h1234);
		send_page(16'h1234);
		set_frames(5'd31);
		send_page(16'h0001);
		send_page(16'h8000);
		set_frames(5'd17);
		send_page(16'h5555);
	endtask

	// a page left in a frame outside the active set gets a duplicate copy
	task automatic test_shrink_grow();
		set_frames(5'd8);
		for (int i = 0; i < 8; i++)
			send_page(16'h0100 + 16'(i));
		set_frames(5'd2);
		send_page(16'h0106);
		set_frames(5'd8);
		send_page(16'h0106);
		send_page(16'h0107);
	endtask

	// phases of references with locality over a small working set plus noise
	task automatic test_random_traffic();
		logic [lrupr_pkg::CFG_W-1:0] settings [14];
		logic [lrupr_pkg::PAGE_PORT_W-1:0] pool [24];
		int pool_n;
		settings = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd0, 5'd17, 5'd4, 5'd8,
			5'd15, 5'd5, 5'd10, 5'd24, 5'd3, 5'd0};
		settings[13] = lrupr_pkg::CFG_W'($urandom_range(0, 31));
		for (int ph = 0; ph < 14; ph++) begin
			set_frames(settings[ph]);
			throttle_in = (ph == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
			throttle_out = (ph == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
			pool_n = int'(active_frames() + $urandom_range(0, 5)) - 1;
			if (pool_n < 1)
				pool_n = 1;
			for (int k = 0; k < pool_n; k++)
				pool[k] = lrupr_pkg::PAGE_PORT_W'($urandom_range(0, 65535));
			pool[0] = (ph % 2) ? 16'hFFFF : 16'h0000;
			for (int n = 0; n < 75; n++) begin
				if ($urandom_range(0, 99) < 85)
					send_page(pool[$urandom_range(0, pool_n - 1)]);
				else
					send_page(lrupr_pkg::PAGE_PORT_W'($urandom_range(0, 65535)));
			end
		end
	endtask

	initial begin
		for (int j = 0; j < NFRAMES; j++) begin
			resident_page[j] = '0;
			resident_valid[j] = 1'b0;
			frame_age[j] = 0;
		end
		hit_count = '0;
		fault_count = '0;
		frames_cfg = lrupr_pkg::FRAMES_IN_USE_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_setting();
		test_frame_limits();
		test_shrink_grow();
		test_random_traffic();

		wait_drained();
		repeat (40) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("checked %0d references: %0d hits, %0d evictions, %0d frame settings",
			n_refs, n_hits, n_evictions, n_settings);
		if (errors == 0)
			$display("lru_page_replacement test passed");
		else
			$display("lru_page_replacement test failed");
		$finish;
	end

endmodule
